// ----- src/piecewise_curve_interpolation_assert.svh -----
// assertion macros for the piecewise curve interpolation block
`ifndef PIECEWISE_CURVE_INTERPOLATION_ASSERT_SVH
`define PIECEWISE_CURVE_INTERPOLATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PCI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PCI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pci_pkg.sv -----
// shared constants and types of the piecewise curve interpolation block
package pci_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int MODE_W      = 2;
	localparam int CFG_W       = COUNT_W;
	localparam int CFG_IDX_W   = 1;
	localparam int STEP_W      = $clog2(VALUE_WIDTH);
	localparam int PRODUCT_W   = 2 * VALUE_WIDTH;

	localparam logic [COUNT_W-1:0] MIN_POINTS = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] MAX_POINTS = COUNT_W'(TABLE_DEPTH);

	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PASS   = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- src/pci_channels.sv -----
// valid/ready channel interfaces for input words and result words
interface pci_in_if import pci_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [ADDR_W-1:0]             point_index;
	logic signed [VALUE_WIDTH-1:0] x_value;
	logic signed [VALUE_WIDTH-1:0] y_value;

	modport source(output valid, operation, point_index, x_value, y_value, input ready);
	modport sink(input valid, operation, point_index, x_value, y_value, output ready);
endinterface

interface pci_out_if import pci_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] y_result;
	logic                          clamped;

	modport source(output valid, y_result, clamped, input ready);
	modport sink(input valid, y_result, clamped, output ready);
endinterface

// ----- src/pci_muldiv.sv -----
// multiply then bit-serial restoring divide: floor(mag * dq / dx), dq <= dx
module pci_muldiv import pci_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] mag,
	input  logic [VALUE_WIDTH-1:0] dq,
	input  logic [VALUE_WIDTH-1:0] dx,
	output logic [VALUE_WIDTH-1:0] quotient,
	output div_status_t            status
);

	logic                   mul_q;
	logic                   run_q;
	logic                   done_q;
	logic [STEP_W-1:0]      cnt_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;

	logic [PRODUCT_W-1:0]   prod;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   ge;

	assign prod  = a_q * b_q;
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(VALUE_WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= mag;
			b_q <= dq;
			d_q <= dx;
		end else if (mul_q) begin
			rem_q <= prod[PRODUCT_W-1:VALUE_WIDTH];
			quo_q <= prod[VALUE_WIDTH-1:0];
		end else if (run_q) begin
			rem_q <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = mul_q | run_q;
	assign status.done = done_q;

endmodule

// ----- src/piecewise_curve_interpolation.sv -----
// piecewise curve interpolation: breakpoint table, span scan, linear/step/hold/pass-through query
// a load writes the table; a pass-through query goes straight to the output register; other
// queries read the first and last breakpoints and stop there for x at or beyond a table end;
// an interior query scans for the closing breakpoint (one table read per scan cycle), then
// linear runs the multiply and serial divide; one word in work at a time
// reset clears control state, mode to linear and point count to 2; the table is not cleared
module piecewise_curve_interpolation import pci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	pci_in_if.sink               item,
	pci_out_if.source            result
);

	`include "piecewise_curve_interpolation_assert.svh"

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FIRST = 4'd1;
	localparam logic [3:0] S_LAST  = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_PREP  = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_FIN   = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;

	logic [3:0]                    state_q;
	logic [MODE_W-1:0]             mode_q;
	logic [COUNT_W-1:0]            count_q;
	logic [ADDR_W-1:0]             idx_q;
	logic signed [VALUE_WIDTH-1:0] x_q;
	logic signed [VALUE_WIDTH-1:0] xp_q;
	logic signed [VALUE_WIDTH-1:0] yp_q;
	logic signed [VALUE_WIDTH-1:0] xn_q;
	logic signed [VALUE_WIDTH-1:0] yn_q;
	logic                          up_q;
	logic signed [VALUE_WIDTH-1:0] res_y_q;
	logic                          res_clamp_q;
	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_y_q;
	logic                          out_clamp_q;

	logic [2*VALUE_WIDTH-1:0]      tbl_mem [TABLE_DEPTH];
	logic [2*VALUE_WIDTH-1:0]      rd_q;
	logic [ADDR_W-1:0]             rd_addr;
	logic signed [VALUE_WIDTH-1:0] rd_x;
	logic signed [VALUE_WIDTH-1:0] rd_y;

	logic [COUNT_W-1:0]            n_eff;
	logic [ADDR_W-1:0]             last_addr;
	logic                          in_fire;
	logic                          out_free;
	logic                          up;
	logic [VALUE_WIDTH-1:0]        mag;
	logic [VALUE_WIDTH-1:0]        dq;
	logic [VALUE_WIDTH-1:0]        dx;
	logic [VALUE_WIDTH-1:0]        dr;
	logic                          div_start;
	logic [VALUE_WIDTH-1:0]        quotient;
	div_status_t                   div_st;

	assign n_eff     = (count_q < MIN_POINTS) ? MIN_POINTS :
	                   (count_q > MAX_POINTS) ? MAX_POINTS : count_q;
	assign last_addr = ADDR_W'(n_eff - COUNT_W'(1));
	assign in_fire   = item.valid && item.ready;
	assign out_free  = !out_valid_q || result.ready;
	assign item.ready = (state_q == S_IDLE);

	assign rd_x = rd_q[VALUE_WIDTH-1:0];
	assign rd_y = rd_q[2*VALUE_WIDTH-1:VALUE_WIDTH];

	// span arithmetic; all differences are non-negative and fit the value width
	assign up  = (yn_q >= yp_q);
	assign mag = up ? VALUE_WIDTH'(yn_q - yp_q) : VALUE_WIDTH'(yp_q - yn_q);
	assign dq  = VALUE_WIDTH'(x_q - xp_q);
	assign dx  = VALUE_WIDTH'(xn_q - xp_q);
	assign dr  = VALUE_WIDTH'(xn_q - x_q);
	assign div_start = (state_q == S_PREP) && (mode_q == MODE_LINEAR);

	always_comb begin
		unique case (state_q)
			S_FIRST: rd_addr = last_addr;
			S_LAST:  rd_addr = ADDR_W'(1);
			S_SCAN:  rd_addr = idx_q + ADDR_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire && item.operation == OP_LOAD) begin
			tbl_mem[item.point_index] <= {item.y_value, item.x_value};
		end
		rd_q <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LINEAR;
			count_q <= MIN_POINTS;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MODE:  mode_q  <= wr_data[MODE_W-1:0];
				CFG_COUNT: count_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && item.operation == OP_QUERY) begin
						state_q <= (mode_q == MODE_PASS) ? S_OUT : S_FIRST;
					end
				end
				S_FIRST: state_q <= S_LAST;
				S_LAST: begin
					if (!(xp_q < x_q) || !(x_q < rd_x)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_x >= x_q) begin
						state_q <= S_PREP;
					end
				end
				S_PREP:  state_q <= (mode_q == MODE_LINEAR) ? S_DIV : S_OUT;
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q         <= item.x_value;
				res_y_q     <= item.x_value;
				res_clamp_q <= 1'b0;
			end
			S_FIRST: begin
				xp_q <= rd_x;
				yp_q <= rd_y;
			end
			S_LAST: begin
				idx_q <= ADDR_W'(1);
				if (!(xp_q < x_q)) begin
					res_y_q     <= yp_q;
					res_clamp_q <= (x_q < xp_q);
				end else begin
					res_y_q     <= rd_y;
					res_clamp_q <= (rd_x < x_q);
				end
			end
			S_SCAN: begin
				if (rd_x >= x_q) begin
					xn_q <= rd_x;
					yn_q <= rd_y;
				end else begin
					xp_q  <= rd_x;
					yp_q  <= rd_y;
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
			S_PREP: begin
				up_q        <= up;
				res_clamp_q <= 1'b0;
				if (mode_q == MODE_STEP) begin
					res_y_q <= (dq < dr) ? yp_q : yn_q;
				end else begin
					res_y_q <= yp_q;
				end
			end
			S_FIN: begin
				res_y_q <= up_q ? (yp_q + $signed(quotient)) : (yp_q - $signed(quotient));
			end
			S_OUT: begin
				if (out_free) begin
					out_y_q     <= res_y_q;
					out_clamp_q <= res_clamp_q;
				end
			end
			default: ;
		endcase
	end

	pci_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.mag      (mag),
		.dq       (dq),
		.dx       (dx),
		.quotient (quotient),
		.status   (div_st)
	);

	assign result.valid    = out_valid_q;
	assign result.y_result = out_y_q;
	assign result.clamped  = out_clamp_q;

	`PCI_ASSERT_SAME(a_span_encloses, state_q == S_PREP, (xp_q < x_q) && (xn_q >= x_q), "bad span")
	`PCI_ASSERT_SAME(a_scan_bound, state_q == S_SCAN, {1'b0, idx_q} < n_eff, "scan overrun")
	`PCI_ASSERT_NEXT(a_div_to_fin, (state_q == S_DIV) && div_st.done, state_q == S_FIN, "done lost")
	`PCI_ASSERT_SAME(a_div_quiet, state_q != S_DIV, !div_st.busy, "divider busy outside divide")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the piecewise curve interpolation block
module tb;
	import pci_pkg::*;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 128;
	localparam int RANDOM_WORDS  = 850;
	localparam int HOLD_CYCLES   = 400;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	localparam value_t X_MIN = 32'sh8000_0000;
	localparam value_t X_MAX = 32'sh7fff_ffff;
	localparam value_t ONE   = 32'sh0001_0000;

	typedef struct {
		value_t y_result;
		logic   clamped;
	} curve_out_t;

	class curve_scoreboard;
		value_t             x_pts[TABLE_DEPTH];
		value_t             y_pts[TABLE_DEPTH];
		logic [MODE_W-1:0]  mode;
		logic [COUNT_W-1:0] count;
		curve_out_t         pending[$];
		int                 errors;

		function new();
			mode = MODE_LINEAR;
			count = MIN_POINTS;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_MODE) begin
				mode = data[MODE_W-1:0];
			end else if (idx == CFG_COUNT) begin
				count = data[COUNT_W-1:0];
			end
		endfunction

		function int points_in_use();
			if (count < MIN_POINTS)
				return MIN_POINTS;
			if (count > MAX_POINTS)
				return MAX_POINTS;
			return count;
		endfunction

		function void take_word(logic op, logic [ADDR_W-1:0] idx, value_t x, value_t y);
			int n;
			int nx;
			value_t xp, xn, yp, yn;
			logic [63:0] dx, dq, mag, q;
			curve_out_t r;
			if (op == OP_LOAD) begin
				x_pts[idx] = x;
				y_pts[idx] = y;
				return;
			end
			n = points_in_use();
			r.clamped = 1'b0;
			if (mode == MODE_PASS) begin
				r.y_result = x;
			end else if (x <= x_pts[0]) begin
				r.y_result = y_pts[0];
				r.clamped = (x < x_pts[0]);
			end else if (x >= x_pts[n-1]) begin
				r.y_result = y_pts[n-1];
				r.clamped = (x > x_pts[n-1]);
			end else begin
				// span closes at the first entry from index 1 at or above x
				nx = n - 1;
				for (int i = n - 1; i >= 1; i--)
					if (x_pts[i] >= x)
						nx = i;
				xp = x_pts[nx-1];
				xn = x_pts[nx];
				yp = y_pts[nx-1];
				yn = y_pts[nx];
				if (mode == MODE_LINEAR) begin
					dx = 64'(longint'(xn) - longint'(xp));
					dq = 64'(longint'(x) - longint'(xp));
					mag = (yn >= yp) ? 64'(longint'(yn) - longint'(yp))
						: 64'(longint'(yp) - longint'(yn));
					q = (mag * dq) / dx;
					r.y_result = (yn >= yp) ? yp + q[VALUE_WIDTH-1:0] : yp - q[VALUE_WIDTH-1:0];
				end else if (mode == MODE_STEP) begin
					r.y_result = (longint'(x) - longint'(xp) < longint'(xn) - longint'(x)) ? yp : yn;
				end else begin
					r.y_result = yp;
				end
			end
			pending.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(value_t y, logic clamped);
			curve_out_t e;
			if (pending.size() == 0) begin
				report($sformatf("result word with none due: y=%h clamped=%b", y, clamped));
				return;
			end
			e = pending.pop_front();
			if (y !== e.y_result)
				report($sformatf("y_result %h, due %h", y, e.y_result));
			if (clamped !== e.clamped)
				report($sformatf("clamped %b, due %b (y %h)", clamped, e.clamped, e.y_result));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	pci_in_if  item_ch();
	pci_out_if result_ch();

	piecewise_curve_interpolation u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	curve_scoreboard sb;
	int burst_left;
	int words_sent;
	int cycles = 0;
	bit hold_req;
	bit slot_written[TABLE_DEPTH];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.y_result, result_ch.clamped);
	end

	// receiver: pattern stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int pat;
		int pat_left;
		hold_left = 0;
		pat = 0;
		pat_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat = $urandom_range(0, 2);
					pat_left = $urandom_range(16, 96);
				end
				pat_left--;
				case (pat)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					default: result_ch.ready <= (pat_left % 4 == 0);
				endcase
			end
		end
	end

	task automatic send_word(logic op, logic [ADDR_W-1:0] idx, value_t x, value_t y);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.point_index <= idx;
		item_ch.x_value <= x;
		item_ch.y_value <= y;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.take_word(op, idx, x, y);
		if (op == OP_LOAD)
			slot_written[idx] = 1'b1;
		burst_left--;
		words_sent++;
	endtask

	task automatic configure(logic [MODE_W-1:0] mode, logic [CFG_W-1:0] count);
		logic [CFG_W-1:0] mode_word;
		mode_word = {(CFG_W - MODE_W)'($urandom), mode};
		wr_en <= 1'b1;
		wr_index <= CFG_MODE;
		wr_data <= mode_word;
		@(posedge clk);
		sb.write_register(CFG_MODE, mode_word);
		wr_index <= CFG_COUNT;
		wr_data <= count;
		@(posedge clk);
		sb.write_register(CFG_COUNT, count);
		wr_en <= 1'b0;
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_table(int n);
		longint step_max;
		longint x;
		int shape;
		int i;
		bit backward;
		value_t xs[TABLE_DEPTH];
		shape = $urandom_range(0, 3);
		case (shape)
			0: step_max = 64'hffff_ffff / n;
			1: step_max = 3 * 65536;
			default: step_max = 3;
		endcase
		if (shape == 0)
			x = longint'(X_MIN) + $urandom_range(0, 32'(step_max));
		else
			x = longint'($signed($urandom)) / 2;
		for (int k = 0; k < n; k++) begin
			if (shape == 3) begin
				xs[k] = $urandom;
			end else begin
				xs[k] = value_t'(x);
				x += $urandom_range(0, 32'(step_max));
			end
		end
		backward = $urandom_range(0, 1);
		for (int k = 0; k < n; k++) begin
			i = backward ? n - 1 - k : k;
			send_word(OP_LOAD, ADDR_W'(i), xs[i], $urandom);
		end
	endtask

	function automatic value_t pick_query_x(int n);
		int i;
		longint xp, xn, lo, hi;
		i = $urandom_range(1, n - 1);
		xp = sb.x_pts[i-1];
		xn = sb.x_pts[i];
		lo = sb.x_pts[0];
		hi = sb.x_pts[n-1];
		case ($urandom_range(0, 9))
			0: return sb.x_pts[$urandom_range(0, n - 1)];
			1, 2, 3: return (xn > xp) ? value_t'(xp + 1 + ($urandom % (xn - xp))) : $urandom;
			4: return value_t'((xp + xn) / 2);
			5: return (lo > longint'(X_MIN)) ? value_t'(lo - 1) : X_MIN;
			6: return (hi < longint'(X_MAX)) ? value_t'(hi + 1) : X_MAX;
			7: return $urandom;
			8: return $urandom_range(0, 1) ? X_MIN : X_MAX;
			default: return value_t'(xp + longint'($urandom_range(0, 2)) - 1);
		endcase
	endfunction

	initial begin
		int n;
		int queries;
		int phase;
		int r;
		int first_random;
		int slot;
		logic [CFG_W-1:0] count;
		logic [MODE_W-1:0] mode;
		bit table_ready;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_MODE;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_LOAD;
		item_ch.point_index = '0;
		item_ch.x_value = '0;
		item_ch.y_value = '0;
		burst_left = 0;
		words_sent = 0;
		hold_req = 1'b0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// full-scale span, falling
		configure(MODE_LINEAR, 2);
		send_word(OP_LOAD, 0, X_MIN, X_MAX);
		send_word(OP_LOAD, 1, X_MAX, X_MIN);
		send_word(OP_QUERY, 0, X_MIN, 0);
		send_word(OP_QUERY, 63, X_MAX, X_MAX);
		send_word(OP_QUERY, 0, 0, 0);
		// clamping on both sides of a narrow table
		send_word(OP_LOAD, 0, -ONE, 0);
		send_word(OP_LOAD, 1, ONE, 3 * ONE);
		send_word(OP_QUERY, 0, X_MIN, 0);
		send_word(OP_QUERY, 0, X_MAX, 0);
		send_word(OP_QUERY, 0, ONE / 2, 0);
		// midpoint tie goes to the upper point; count below range acts as 2
		settle();
		configure(MODE_STEP, 0);
		send_word(OP_QUERY, 0, 0, 0);
		send_word(OP_QUERY, 0, -1, 0);
		settle();
		configure(MODE_HOLD, 1);
		send_word(OP_QUERY, 0, ONE - 1, 0);
		settle();
		configure(MODE_PASS, 2);
		send_word(OP_QUERY, 0, X_MIN, 0);
		send_word(OP_QUERY, 0, X_MAX, 0);
		// table out of order: last x below the one before it
		send_word(OP_LOAD, 2, 0, -ONE);
		settle();
		configure(MODE_LINEAR, 3);
		send_word(OP_QUERY, 0, -100, 0);
		send_word(OP_QUERY, 0, 0, 0);
		send_word(OP_QUERY, 0, ONE, 0);
		send_word(OP_QUERY, 0, -ONE, 0);

		first_random = words_sent;
		phase = 0;
		while (words_sent < first_random + RANDOM_WORDS) begin
			settle();
			if (phase == 0) begin
				count = MAX_POINTS;
			end else if (phase == 1) begin
				count = 127;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6)
					count = CFG_W'($urandom_range(2, 8));
				else if (r < 8)
					count = CFG_W'($urandom_range(9, 64));
				else if (r == 8)
					count = CFG_W'($urandom_range(0, 1));
				else
					count = CFG_W'($urandom_range(65, 127));
			end
			case ($urandom_range(0, 9))
				0, 1, 2: mode = MODE_LINEAR;
				3, 4, 5: mode = MODE_STEP;
				6, 7, 8: mode = MODE_HOLD;
				default: mode = MODE_PASS;
			endcase
			configure(mode, count);
			n = sb.points_in_use();
			table_ready = 1'b1;
			for (int i = 0; i < n; i++)
				if (!slot_written[i])
					table_ready = 1'b0;
			if (!table_ready || $urandom_range(0, 2) != 0)
				load_table(n);
			if (phase == 2)
				hold_req = 1'b1;
			queries = (phase == 2) ? 40 : $urandom_range(4, 40);
			repeat (queries) begin
				if ($urandom_range(0, 7) == 0) begin
					slot = $urandom_range(0, TABLE_DEPTH - 1);
					send_word(OP_LOAD, ADDR_W'(slot), $urandom, $urandom);
				end
				send_word(OP_QUERY, ADDR_W'($urandom), pick_query_x(n), $urandom);
			end
			phase++;
		end

		settle();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- piecewise_curve_interpolation.f -----
+incdir+src
src/pci_pkg.sv
src/pci_channels.sv
src/pci_muldiv.sv
src/piecewise_curve_interpolation.sv
sim/tb.sv
